FILE: rtl/page_table_builder_2mb_macros.svh
// Assertion macros for the 2 MB page table builder.
`ifndef PAGE_TABLE_BUILDER_2MB_MACROS_SVH
`define PAGE_TABLE_BUILDER_2MB_MACROS_SVH

`ifndef ASSERT_OFF

// Condition must hold in every cycle outside reset.
`define PTB_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("page table builder assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page table builder sequence assertion failed");

`else

`define PTB_ASSERT(lbl, clk, rst_n, cond)
`define PTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/ptb_pkg.sv
// Shared types, constants and helpers for the 2 MB page table builder.
package ptb_pkg;

    localparam int POOL_PAGES_DEF    = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int FRAME_W           = 40;
    localparam int PFRAME_W          = 31;
    localparam int VPAGE_W           = 27;
    localparam int ENTRY_W           = 64;
    localparam int PAGE_OUT_W        = 6;

    // Present | writable | large page
    localparam logic [7:0]  LEAF_ATTR = 8'h83;
    // Present | writable
    localparam logic [11:0] PTR_ATTR  = 12'h003;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TOP_CHK,
        ST_MID_CHK,
        ST_COMMIT,
        ST_WR_LEAF,
        ST_RESULT
    } ptb_state_t;

    typedef struct packed {
        logic clear_step;
        logic load_in;
        logic rd_mid;
        logic decide;
        logic wr_ptr;
        logic wr_leaf;
        logic load_out;
    } ptb_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic top_hit;
        logic full;
        logic need_leaf;
        logic out_busy;
    } ptb_stat_t;

    // Table pointer to pool page: ((base + page) mod 2^40) * 4096 | present | writable
    function automatic logic [ENTRY_W-1:0] make_ptr(input logic [FRAME_W-1:0] base,
                                                    input logic [FRAME_W-1:0] page);
        logic [FRAME_W-1:0] frame;
        frame = base + page;
        return {12'b0, frame, PTR_ATTR};
    endfunction

    // Leaf descriptor for a 2 MB frame
    function automatic logic [ENTRY_W-1:0] make_leaf(input logic [PFRAME_W-1:0] pframe);
        return {12'b0, pframe, 13'b0, LEAF_ATTR};
    endfunction

endpackage

FILE: rtl/page_table_builder_2mb.sv
// The time from input beat to result valid depends on walk depth, tables made and pool full.
// Requests are taken one at a time; the single-write-port table pool takes up to one
// pointer read and up to two writes per request.
// Reset: asynchronous, active low; then a clearing pass over all POOL_PAGES*512 pool entries
// (32768 at default) zeroes both tables with in_ready low; config beats still taken.
// Top level: x86-64 style 2 MB page mapper over a bump-allocated pool of table pages.
`include "page_table_builder_2mb_macros.svh"

module page_table_builder_2mb #(
    parameter int POOL_PAGES = ptb_pkg::POOL_PAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration write channel: pool base frame number
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ptb_pkg::FRAME_W-1:0]     pool_base_frame,

    // Request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ptb_pkg::PFRAME_W-1:0]    phys_frame,
    input  logic [ptb_pkg::VPAGE_W-1:0]     virt_page,

    // Result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ptb_pkg::ENTRY_W-1:0]     leaf_entry,
    output logic                            made_mid_table,
    output logic                            made_leaf_table,
    output logic [ptb_pkg::PAGE_OUT_W-1:0]  mid_table_page,
    output logic [ptb_pkg::PAGE_OUT_W-1:0]  leaf_table_page,
    output logic                            pool_full
);
    import ptb_pkg::*;

    ptb_cmd_t  cmd;
    ptb_stat_t stat;
    logic      full_fields_zero;

    // The base register is a plain flop: accept every config beat at once.
    assign cfg_ready = 1'b1;

    // Sequencer: clear sweep, then per request
    //   top read -> (mid read) -> allocate -> pointer/leaf writes -> result load.
    // The result register parts the output side: a request is accepted while the
    // previous result still waits, and only the final load waits on out_ready.
    ptb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: top table and pool memories, pointer checks against the current
    // base, bump allocator and the result register.
    ptb_dpath #(
        .POOL_PAGES (POOL_PAGES)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .pool_base_frame (pool_base_frame),
        .phys_frame      (phys_frame),
        .virt_page       (virt_page),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .leaf_entry      (leaf_entry),
        .made_mid_table  (made_mid_table),
        .made_leaf_table (made_leaf_table),
        .mid_table_page  (mid_table_page),
        .leaf_table_page (leaf_table_page),
        .pool_full       (pool_full)
    );

    // Every field but the full flag is zero
    assign full_fields_zero = (leaf_entry == '0) && !made_mid_table && !made_leaf_table
                              && (mid_table_page == '0) && (leaf_table_page == '0);

    // One request in flight: after an input beat, hold off the next.
    `PTB_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // A full-pool result carries nothing else.
    `PTB_ASSERT(a_full_clean, clk, rst_n, !(out_valid && pool_full) || full_fields_zero)

    // A written leaf always carries present, writable and large-page bits.
    `PTB_ASSERT(a_leaf_attr, clk, rst_n, !(out_valid && !pool_full) || (leaf_entry[7:0] == LEAF_ATTR))

    // A new second-level table always comes with a new third-level table.
    `PTB_ASSERT(a_mid_implies_leaf, clk, rst_n, !(out_valid && made_mid_table) || made_leaf_table)

endmodule

FILE: rtl/ptb_ctrl.sv
// Sequencer for the table walk, allocation and write-back of one mapping request.
module ptb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ptb_pkg::ptb_stat_t stat,
    output ptb_pkg::ptb_cmd_t  cmd
);
    import ptb_pkg::*;

    ptb_state_t state_reg;
    ptb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_TOP_CHK;
            end
            ST_TOP_CHK:
            begin
                state_next = stat.top_hit ? ST_MID_CHK : ST_COMMIT;
            end
            ST_MID_CHK:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!stat.full && stat.need_leaf)
                    state_next = ST_WR_LEAF;
                else
                    state_next = ST_RESULT;
            end
            ST_WR_LEAF:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!stat.out_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_TOP_CHK:
            begin
                // hit: fetch mid entry; miss: both tables must be made
                cmd.rd_mid = stat.top_hit;
                cmd.decide = !stat.top_hit;
            end
            ST_MID_CHK:
            begin
                cmd.decide = 1'b1;
            end
            ST_COMMIT:
            begin
                if (!stat.full)
                begin
                    cmd.wr_ptr  = stat.need_leaf;
                    cmd.wr_leaf = !stat.need_leaf;
                end
            end
            ST_WR_LEAF:
            begin
                cmd.wr_leaf = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.load_out = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/ptb_dpath.sv
// Table memories, allocator, pointer checks and result register.
module ptb_dpath #(
    parameter int POOL_PAGES = ptb_pkg::POOL_PAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ptb_pkg::ptb_cmd_t               cmd,
    output ptb_pkg::ptb_stat_t              stat,
    input  logic                            cfg_valid,
    input  logic [ptb_pkg::FRAME_W-1:0]     pool_base_frame,
    input  logic [ptb_pkg::PFRAME_W-1:0]    phys_frame,
    input  logic [ptb_pkg::VPAGE_W-1:0]     virt_page,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ptb_pkg::ENTRY_W-1:0]     leaf_entry,
    output logic                            made_mid_table,
    output logic                            made_leaf_table,
    output logic [ptb_pkg::PAGE_OUT_W-1:0]  mid_table_page,
    output logic [ptb_pkg::PAGE_OUT_W-1:0]  leaf_table_page,
    output logic                            pool_full
);
    import ptb_pkg::*;

    localparam int PAGE_W       = $clog2(POOL_PAGES);
    localparam int CNT_W        = $clog2(POOL_PAGES + 1);
    localparam int CW1          = CNT_W + 1;
    localparam int POOL_ENTRIES = POOL_PAGES * ENTRIES_PER_TABLE;
    localparam int PA_W         = PAGE_W + IDX_W;

    logic [ENTRY_W-1:0]  top_mem  [ENTRIES_PER_TABLE];
    logic [ENTRY_W-1:0]  pool_mem [POOL_ENTRIES];

    logic [FRAME_W-1:0]  base_reg;
    logic [CNT_W-1:0]    nfp_reg;
    logic [PA_W-1:0]     clr_cnt_reg;
    logic [PFRAME_W-1:0] pf_reg;
    logic [VPAGE_W-1:0]  vp_reg;
    logic [ENTRY_W-1:0]  top_rd_reg;
    logic [ENTRY_W-1:0]  pool_rd_reg;
    logic                need_mid_reg;
    logic                need_leaf_reg;
    logic                full_reg;
    logic [PAGE_W-1:0]   mid_pg_reg;
    logic [PAGE_W-1:0]   leaf_pg_reg;
    logic                out_valid_reg;
    logic [ENTRY_W-1:0]  leaf_out_reg;
    logic                made_mid_reg;
    logic                made_leaf_reg;
    logic [PAGE_OUT_W-1:0] mid_out_reg;
    logic [PAGE_OUT_W-1:0] leaf_out_pg_reg;
    logic                full_out_reg;

    logic [IDX_W-1:0]    top_idx;
    logic [IDX_W-1:0]    mid_idx;
    logic [IDX_W-1:0]    leaf_idx;
    logic [FRAME_W-1:0]  top_diff;
    logic [FRAME_W-1:0]  mid_diff;
    logic                top_hit;
    logic                mid_hit;
    logic                need_mid;
    logic                need_leaf;
    logic [CW1-1:0]      needed;
    logic [CW1-1:0]      avail;
    logic                no_room;
    logic [PAGE_W-1:0]   nfp_page;
    logic [PAGE_W-1:0]   nfp_page_p1;
    logic                pool_we;
    logic [PA_W-1:0]     pool_wa;
    logic [ENTRY_W-1:0]  pool_wd;
    logic                top_we;
    logic [IDX_W-1:0]    top_wa;
    logic [ENTRY_W-1:0]  top_wd;

    assign top_idx  = vp_reg[3*IDX_W-1:2*IDX_W];
    assign mid_idx  = vp_reg[2*IDX_W-1:IDX_W];
    assign leaf_idx = vp_reg[IDX_W-1:0];

    // Present entry that names an allocated page under the current base
    assign top_diff = top_rd_reg[FRAME_W+11:12] - base_reg;
    assign mid_diff = pool_rd_reg[FRAME_W+11:12] - base_reg;
    assign top_hit  = top_rd_reg[0] && (top_diff < FRAME_W'(nfp_reg));
    assign mid_hit  = pool_rd_reg[0] && (mid_diff < FRAME_W'(nfp_reg));

    assign need_mid  = !top_hit;
    assign need_leaf = need_mid || !mid_hit;
    assign needed    = CW1'(need_mid) + CW1'(need_leaf);
    assign avail     = CW1'(POOL_PAGES) - CW1'(nfp_reg);
    assign no_room   = needed > avail;

    assign nfp_page    = PAGE_W'(nfp_reg);
    assign nfp_page_p1 = PAGE_W'(nfp_reg + CNT_W'(1));

    // Configuration, allocator and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            nfp_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                base_reg <= pool_base_frame;
            if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + PA_W'(1);
            if (cmd.decide && !no_room)
                nfp_reg <= nfp_reg + CNT_W'(needed);
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Request and decision registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            pf_reg <= phys_frame;
            vp_reg <= virt_page;
        end
        if (cmd.decide)
        begin
            need_mid_reg  <= need_mid;
            need_leaf_reg <= need_leaf;
            full_reg      <= no_room;
            mid_pg_reg    <= need_mid ? nfp_page : top_diff[PAGE_W-1:0];
            if (!need_leaf)
                leaf_pg_reg <= mid_diff[PAGE_W-1:0];
            else if (need_mid)
                leaf_pg_reg <= nfp_page_p1;
            else
                leaf_pg_reg <= nfp_page;
        end
    end

    // Top table: clear sweep, pointer write, read at request accept
    always_comb
    begin
        top_we = cmd.clear_step || (cmd.wr_leaf && need_mid_reg);
        top_wa = cmd.clear_step ? clr_cnt_reg[IDX_W-1:0] : top_idx;
        top_wd = cmd.clear_step ? '0 : make_ptr(base_reg, FRAME_W'(mid_pg_reg));
    end

    always_ff @(posedge clk)
    begin
        if (top_we)
            top_mem[top_wa] <= top_wd;
        if (cmd.load_in)
            top_rd_reg <= top_mem[virt_page[3*IDX_W-1:2*IDX_W]];
    end

    // Pool: one write port shared by clear, mid pointer and leaf writes
    always_comb
    begin
        pool_we = cmd.clear_step || cmd.wr_ptr || cmd.wr_leaf;
        if (cmd.clear_step)
        begin
            pool_wa = clr_cnt_reg;
            pool_wd = '0;
        end
        else if (cmd.wr_ptr)
        begin
            pool_wa = {mid_pg_reg, mid_idx};
            pool_wd = make_ptr(base_reg, FRAME_W'(leaf_pg_reg));
        end
        else
        begin
            pool_wa = {leaf_pg_reg, leaf_idx};
            pool_wd = make_leaf(pf_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pool_we)
            pool_mem[pool_wa] <= pool_wd;
        if (cmd.rd_mid)
            pool_rd_reg <= pool_mem[{top_diff[PAGE_W-1:0], mid_idx}];
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (full_reg)
            begin
                leaf_out_reg    <= '0;
                made_mid_reg    <= 1'b0;
                made_leaf_reg   <= 1'b0;
                mid_out_reg     <= '0;
                leaf_out_pg_reg <= '0;
                full_out_reg    <= 1'b1;
            end
            else
            begin
                leaf_out_reg    <= make_leaf(pf_reg);
                made_mid_reg    <= need_mid_reg;
                made_leaf_reg   <= need_leaf_reg;
                mid_out_reg     <= PAGE_OUT_W'(mid_pg_reg);
                leaf_out_pg_reg <= PAGE_OUT_W'(leaf_pg_reg);
                full_out_reg    <= 1'b0;
            end
        end
    end

    assign stat.clear_done = clr_cnt_reg == PA_W'(POOL_ENTRIES - 1);
    assign stat.top_hit    = top_hit;
    assign stat.full       = full_reg;
    assign stat.need_leaf  = need_leaf_reg;
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign leaf_entry      = leaf_out_reg;
    assign made_mid_table  = made_mid_reg;
    assign made_leaf_table = made_leaf_reg;
    assign mid_table_page  = mid_out_reg;
    assign leaf_table_page = leaf_out_pg_reg;
    assign pool_full       = full_out_reg;

endmodule
